@@ design/assert_macros.svh @@
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another on the following clock edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fsba_pkg.sv @@
// Shared types and codes for the segment allocator
`timescale 1ns / 1ps
package fsba_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int SIZE_BITS    = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOOWNER  = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic REG_FIT   = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  owner_id;
        logic [15:0] request_size;
    } fsba_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] free_total;
        logic [5:0]  free_segments;
        logic [5:0]  used_segments;
        logic [15:0] external_fragmentation;
    } fsba_out_t;
endpackage

@@ design/fit_strategy_block_allocator_top.sv @@
// Segment allocator top level: first, best or worst fit over a segment table
//
//  channel | ports                       | carries
//  input   | s_valid s_ready s_data      | opcode, owner_id, request_size
//  result  | m_valid m_ready m_data      | status, counts, free total, fragmentation
//  config  | cfg_we cfg_index cfg_wdata  | fit_strategy, total_size
//
// One item at a time; the state machine walks the table entry by entry, with
// a search pass and a shift pass on split, or a find pass and a merge scan
// with a shift pass per merge on free, and then a totals pass.
// Reset leaves one free segment of size 16'hFFFF; no clearing pass.
// A result waits in the output register; s_ready rises again once it is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fit_strategy_block_allocator_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsba_pkg::fsba_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fsba_pkg::fsba_out_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata
);
    import fsba_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_SPLIT  = 4'd4;
    localparam logic [3:0] S_FIND   = 4'd5;
    localparam logic [3:0] S_MERGE  = 4'd6;
    localparam logic [3:0] S_MSHIFT = 4'd7;
    localparam logic [3:0] S_SUM    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // Table as registers; entry count is small, each access uses one or two indices
    logic [SIZE_BITS-1:0] start_mem [MAX_SEGMENTS];
    logic [SIZE_BITS-1:0] size_mem  [MAX_SEGMENTS];
    logic [7:0]           owner_mem [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] free_reg, free_next;

    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  pick_reg, pick_next;
    logic           found_reg, found_next;
    logic [1:0]     fit_reg;
    fsba_in_t       req_reg;
    logic [2:0]     status_reg, status_next;
    logic [SIZE_BITS-1:0] psize_reg, psize_next;
    logic [SIZE_BITS:0]   sum_reg, sum_next;
    logic [CW-1:0]  nfree_reg, nfree_next;
    fsba_out_t      out_reg;
    logic           mvalid_reg;

    logic [IW-1:0]  ia, ib;
    logic [SIZE_BITS-1:0] req_sz;
    logic           cur_free, cur_fits, better;

    assign req_sz   = SIZE_BITS'(req_reg.request_size);
    assign ia       = idx_reg[IW-1:0];
    assign ib       = IW'(idx_reg + CW'(1));
    assign cur_free = free_reg[ia];
    assign cur_fits = cur_free && (size_mem[ia] >= req_sz);
    always_comb begin
        case (fit_reg)
            FIT_BEST:  better = size_mem[ia] < psize_reg;
            FIT_WORST: better = size_mem[ia] > psize_reg;
            default:   better = 1'b0;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pick_next   = pick_reg;
        found_next  = found_reg;
        status_next = status_reg;
        psize_next  = psize_reg;
        sum_next    = sum_reg;
        nfree_next  = nfree_reg;
        free_next   = free_reg;
        unique case (state_reg)
            S_IDLE: begin
                idx_next   = '0;
                found_next = 1'b0;
                if (s_valid && s_ready) begin
                    if (s_data.opcode == OP_FREE) begin
                        state_next = S_FIND;
                    end else if (s_data.request_size == 16'd0) begin
                        status_next = ST_ZERO;
                        state_next  = S_SUM;
                    end else begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (idx_reg >= count_reg) begin
                    state_next = S_DEC;
                end else begin
                    if (cur_fits && (!found_reg || better)) begin
                        found_next = 1'b1;
                        pick_next  = ia;
                        psize_next = size_mem[ia];
                    end
                    if (cur_fits && !found_reg &&
                        fit_reg != FIT_BEST && fit_reg != FIT_WORST) begin
                        state_next = S_DEC;
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DEC: begin
                if (!found_reg) begin
                    status_next = ST_NOFIT;
                    state_next  = S_SUM;
                    idx_next    = '0;
                end else if (psize_reg == req_sz) begin
                    status_next = ST_OK;
                    free_next[pick_reg] = 1'b0;
                    state_next  = S_SUM;
                    idx_next    = '0;
                end else if (count_reg >= MAXC) begin
                    status_next = ST_FULL;
                    state_next  = S_SUM;
                    idx_next    = '0;
                end else begin
                    idx_next   = count_reg;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // move entries up by one, from the top down to pick+2
                if (idx_reg > CW'(pick_reg) + CW'(1)) begin
                    free_next[ia] = free_reg[IW'(idx_reg - CW'(1))];
                    idx_next      = idx_reg - CW'(1);
                end else begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: begin
                free_next[IW'(CW'(pick_reg) + CW'(1))] = 1'b1;
                free_next[pick_reg] = 1'b0;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                state_next  = S_SUM;
                idx_next    = '0;
            end
            S_FIND: begin
                if (idx_reg >= count_reg) begin
                    status_next = ST_NOOWNER;
                    state_next  = S_SUM;
                    idx_next    = '0;
                end else if (!cur_free && owner_mem[ia] == req_reg.owner_id) begin
                    free_next[ia] = 1'b1;
                    status_next   = ST_OK;
                    state_next    = S_MERGE;
                    idx_next      = '0;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_MERGE: begin
                if (idx_reg + CW'(1) >= count_reg) begin
                    state_next = S_SUM;
                    idx_next   = '0;
                end else if (cur_free && free_reg[ib]) begin
                    pick_next  = ia;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_MSHIFT;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_MSHIFT: begin
                // pull entries down by one over the absorbed slot
                if (idx_reg + CW'(1) < count_reg) begin
                    free_next[ia] = free_reg[ib];
                    idx_next      = idx_reg + CW'(1);
                end else begin
                    count_next = count_reg - CW'(1);
                    idx_next   = CW'(pick_reg);
                    state_next = S_MERGE;
                end
            end
            S_SUM: begin
                if (idx_reg >= count_reg) begin
                    state_next = S_OUT;
                end else begin
                    if (cur_free) begin
                        sum_next   = sum_reg + (SIZE_BITS+1)'(size_mem[ia]);
                        nfree_next = nfree_reg + CW'(1);
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_OUT: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg != S_SUM) begin
            sum_next   = '0;
            nfree_next = '0;
        end
        if (state_reg == S_SUM && idx_reg >= count_reg) begin
            sum_next   = sum_reg;
            nfree_next = nfree_reg;
        end
    end

    // Table data writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mem[0] <= '0;
            size_mem[0]  <= SIZE_BITS'(16'hFFFF);
            owner_mem[0] <= '0;
        end else if (cfg_we && cfg_index == REG_TOTAL) begin
            start_mem[0] <= '0;
            size_mem[0]  <= SIZE_BITS'(cfg_wdata);
            owner_mem[0] <= '0;
        end else begin
            unique case (state_reg)
                S_DEC: begin
                    if (found_reg && psize_reg == req_sz)
                        owner_mem[pick_reg] <= req_reg.owner_id;
                end
                S_SHIFT: begin
                    if (idx_reg > CW'(pick_reg) + CW'(1)) begin
                        start_mem[ia] <= start_mem[IW'(idx_reg - CW'(1))];
                        size_mem[ia]  <= size_mem[IW'(idx_reg - CW'(1))];
                        owner_mem[ia] <= owner_mem[IW'(idx_reg - CW'(1))];
                    end
                end
                S_SPLIT: begin
                    start_mem[IW'(CW'(pick_reg) + CW'(1))] <= start_mem[pick_reg] + req_sz;
                    size_mem[IW'(CW'(pick_reg) + CW'(1))]  <= psize_reg - req_sz;
                    owner_mem[IW'(CW'(pick_reg) + CW'(1))] <= '0;
                    size_mem[pick_reg]  <= req_sz;
                    owner_mem[pick_reg] <= req_reg.owner_id;
                end
                S_FIND: begin
                    if (idx_reg < count_reg && !cur_free &&
                        owner_mem[ia] == req_reg.owner_id)
                        owner_mem[ia] <= '0;
                end
                S_MERGE: begin
                    if (idx_reg + CW'(1) < count_reg && cur_free && free_reg[ib])
                        size_mem[ia] <= size_mem[ia] + size_mem[ib];
                end
                S_MSHIFT: begin
                    if (idx_reg + CW'(1) < count_reg) begin
                        start_mem[ia] <= start_mem[ib];
                        size_mem[ia]  <= size_mem[ib];
                        owner_mem[ia] <= owner_mem[ib];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= CW'(1);
            free_reg   <= MAX_SEGMENTS'(1);
            fit_reg    <= FIT_FIRST;
            mvalid_reg <= 1'b0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            sum_reg    <= '0;
            nfree_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            sum_reg   <= sum_next;
            nfree_reg <= nfree_next;
            if (cfg_we && cfg_index == REG_TOTAL) begin
                count_reg <= CW'(1);
                free_reg  <= MAX_SEGMENTS'(1);
            end else begin
                count_reg <= count_next;
                free_reg  <= free_next;
            end
            if (cfg_we && cfg_index == REG_FIT)
                fit_reg <= cfg_wdata[1:0];
            if (state_reg == S_OUT)
                mvalid_reg <= 1'b1;
            else if (m_ready)
                mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        pick_reg   <= pick_next;
        psize_reg  <= psize_next;
        status_reg <= status_next;
        if (s_valid && s_ready)
            req_reg <= s_data;
        if (state_reg == S_OUT) begin
            out_reg.status        <= status_reg;
            out_reg.free_total    <= 16'(sum_reg);
            out_reg.free_segments <= 6'(nfree_reg);
            out_reg.used_segments <= 6'(count_reg - nfree_reg);
            out_reg.external_fragmentation <=
                (nfree_reg > CW'(1)) ? 16'(sum_reg) : 16'd0;
        end
    end

    `ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1,
        count_reg >= CW'(1) && count_reg <= MAXC, "segment count out of range")
    `ASSERT_IMPL(a_busy_not_ready, aclk, aresetn, state_reg != S_IDLE, !s_ready,
        "ready while busy")
    `ASSERT_NEXT(a_out_valid, aclk, aresetn, state_reg == S_OUT, m_valid,
        "result not presented")
endmodule

@@ test/fit_strategy_block_allocator_checker.sv @@
// Checker: watches the allocator channels, predicts each result and compares
`timescale 1ns / 1ps
module fit_strategy_block_allocator_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  fsba_pkg::fsba_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  fsba_pkg::fsba_out_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata,
    output int                  fail_count,
    output int                  pending
);
    import fsba_pkg::*;

    localparam int NSEG = MAX_SEGMENTS;

    logic [15:0] seg_base [NSEG];
    logic [15:0] seg_len [NSEG];
    logic        seg_open [NSEG];
    logic [7:0]  seg_owner [NSEG];
    int          seg_cnt;
    logic [1:0]  strategy;
    logic [15:0] mem_size;
    fsba_out_t   results_due[$];

    assign pending = results_due.size();

    function automatic void rebuild_table();
        for (int i = 0; i < NSEG; i++) begin
            seg_base[i] = '0;
            seg_len[i] = '0;
            seg_open[i] = 1'b0;
            seg_owner[i] = '0;
        end
        seg_len[0] = mem_size;
        seg_open[0] = 1'b1;
        seg_cnt = 1;
    endfunction

    function automatic logic [2:0] place_segment(logic [7:0] owner, logic [15:0] req);
        int pick;
        pick = -1;
        if (req == 0) return ST_ZERO;
        for (int i = 0; i < seg_cnt; i++) begin
            if (!seg_open[i] || seg_len[i] < req) continue;
            if (pick < 0) begin
                pick = i;
                if (strategy != FIT_BEST && strategy != FIT_WORST) break;
            end else if (strategy == FIT_BEST && seg_len[i] < seg_len[pick]) begin
                pick = i;
            end else if (strategy == FIT_WORST && seg_len[i] > seg_len[pick]) begin
                pick = i;
            end
        end
        if (pick < 0) return ST_NOFIT;
        if (seg_len[pick] != req) begin
            if (seg_cnt >= NSEG) return ST_FULL;
            for (int j = seg_cnt; j > pick + 1; j--) begin
                seg_base[j] = seg_base[j-1];
                seg_len[j] = seg_len[j-1];
                seg_open[j] = seg_open[j-1];
                seg_owner[j] = seg_owner[j-1];
            end
            seg_base[pick+1] = seg_base[pick] + req;
            seg_len[pick+1] = seg_len[pick] - req;
            seg_open[pick+1] = 1'b1;
            seg_owner[pick+1] = '0;
            seg_len[pick] = req;
            seg_cnt++;
        end
        seg_open[pick] = 1'b0;
        seg_owner[pick] = owner;
        return ST_OK;
    endfunction

    function automatic void coalesce_free();
        int i;
        i = 0;
        while (i + 1 < seg_cnt) begin
            if (seg_open[i] && seg_open[i+1]) begin
                seg_len[i] = seg_len[i] + seg_len[i+1];
                for (int j = i + 1; j + 1 < seg_cnt; j++) begin
                    seg_base[j] = seg_base[j+1];
                    seg_len[j] = seg_len[j+1];
                    seg_open[j] = seg_open[j+1];
                    seg_owner[j] = seg_owner[j+1];
                end
                seg_cnt--;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic logic [2:0] release_owner(logic [7:0] owner);
        for (int i = 0; i < seg_cnt; i++) begin
            if (!seg_open[i] && seg_owner[i] == owner) begin
                seg_open[i] = 1'b1;
                seg_owner[i] = '0;
                coalesce_free();
                return ST_OK;
            end
        end
        return ST_NOOWNER;
    endfunction

    function automatic fsba_out_t allocator_result(fsba_in_t req);
        fsba_out_t r;
        int nfree, nused;
        logic [31:0] sum;
        nfree = 0;
        nused = 0;
        sum = 0;
        r.status = (req.opcode == OP_FREE) ? release_owner(req.owner_id)
                                           : place_segment(req.owner_id, req.request_size);
        for (int i = 0; i < seg_cnt; i++) begin
            if (seg_open[i]) begin
                nfree++;
                sum += seg_len[i];
            end else begin
                nused++;
            end
        end
        r.free_total = sum[15:0];
        r.free_segments = nfree[5:0];
        r.used_segments = nused[5:0];
        r.external_fragmentation = (nfree > 1) ? sum[15:0] : 16'd0;
        return r;
    endfunction

    always @(posedge aclk) begin
        fsba_out_t want;
        if (!aresetn) begin
            strategy = FIT_FIRST;
            mem_size = 16'hFFFF;
            rebuild_table();
            results_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_FIT) begin
                    strategy = cfg_wdata[1:0];
                end else begin
                    mem_size = cfg_wdata;
                    rebuild_table();
                end
            end
            if (s_valid && s_ready) results_due.push_back(allocator_result(s_data));
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%t: unexpected result beat %p", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    if (want !== m_data) begin
                        $display("%t: mismatch expected %p actual %p", $time, want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/fit_strategy_block_allocator_top_test.sv @@
// Testbench top: drives requests and register writes, gives the verdict
`timescale 1ns / 1ps
module fit_strategy_block_allocator_top_test;
    import fsba_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    fsba_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    fsba_out_t   m_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          burst_left;
    bit          rx_steady;

    fit_strategy_block_allocator_top u_top (.*);

    fit_strategy_block_allocator_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // bail out on a hang: room for ~1300 items plus gaps and stalls
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("** fit_strategy_block_allocator_top: FAILED **");
                $finish;
            end
        end
    end

    // receiver stalls: steady-ready stretches alternate with random stalls
    initial begin
        m_ready = 1'b0;
        rx_steady = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) rx_steady = ~rx_steady;
            m_ready <= rx_steady ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_beat(logic op, logic [7:0] owner, logic [15:0] size);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
        burst_left--;
        s_valid = 1'b1;
        s_data = '{opcode: op, owner_id: owner, request_size: size};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        // drain, then let the block settle before touching its table
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, int owners, int max_req);
        logic [15:0] sz;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: sz = 16'($urandom_range(0, 65535));
                1: sz = 16'd0;
                default: sz = 16'($urandom_range(1, max_req));
            endcase
            if ($urandom_range(0, 9) < 4)
                send_beat(OP_FREE, 8'($urandom_range(0, owners)), 16'($urandom));
            else
                send_beat(OP_ALLOC, 8'($urandom_range(0, owners)), sz);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_FIT;
        cfg_wdata = '0;
        burst_left = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, exact fit, unknown owner, zero request
        send_beat(OP_ALLOC, 8'd0, 16'd0);
        send_beat(OP_ALLOC, 8'hFF, 16'd100);
        send_beat(OP_ALLOC, 8'h01, 16'd65535);
        send_beat(OP_ALLOC, 8'h02, 16'hFFFF);
        send_beat(OP_FREE, 8'h7E, 16'h0);
        send_beat(OP_FREE, 8'hFF, 16'hFFFF);
        send_beat(OP_FREE, 8'h01, 16'h0);
        send_beat(OP_ALLOC, 8'hAA, 16'd65535);
        send_beat(OP_FREE, 8'hAA, 16'h0);
        // fill the table with one-unit splits to reach the full case
        write_reg(REG_TOTAL, 16'd40);
        for (int i = 0; i < 33; i++) send_beat(OP_ALLOC, 8'(i), 16'd1);
        send_beat(OP_ALLOC, 8'h55, 16'd9);
        send_beat(OP_FREE, 8'd3, 16'h0);
        send_beat(OP_ALLOC, 8'h56, 16'd1);
        write_reg(REG_TOTAL, 16'd0);
        send_beat(OP_ALLOC, 8'h01, 16'd1);
        send_beat(OP_ALLOC, 8'h01, 16'd0);

        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_FIT, 2'(phase % 4));
            case (phase % 4)
                0: write_reg(REG_TOTAL, 16'hFFFF);
                1: write_reg(REG_TOTAL, 16'd1);
                2: write_reg(REG_TOTAL, 16'd200);
                default: write_reg(REG_TOTAL, 16'($urandom_range(1, 65535)));
            endcase
            random_phase(160, (phase % 2) ? 255 : 15, (phase % 4 == 2) ? 40 : 3000);
        end

        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0)
            $display("** fit_strategy_block_allocator_top: PASSED **");
        else
            $display("** fit_strategy_block_allocator_top: FAILED **");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/fsba_pkg.sv
design/fit_strategy_block_allocator_top.sv
test/fit_strategy_block_allocator_checker.sv
test/fit_strategy_block_allocator_top_test.sv
